>>> hw/rtl/section_extent_sorter_top_defines.svh
// assertion helpers shared by the sorter modules
`ifndef SECTION_EXTENT_SORTER_TOP_DEFINES_SVH
`define SECTION_EXTENT_SORTER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SES_CHK_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SES_CHK_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ses_pkg.sv
package ses_pkg;

    localparam int SES_MAX_SECTIONS = 32;
    localparam int SES_OFF_W        = 32;
    localparam int SES_KIND_W       = 7;

    typedef struct packed {
        logic [SES_OFF_W-1:0]  section_offset;
        logic [SES_KIND_W-1:0] section_kind;
        logic                  last_record;
    } t_in_beat;

    typedef struct packed {
        logic [SES_OFF_W-1:0]  start_offset;
        logic [SES_OFF_W-1:0]  end_offset;
        logic [SES_KIND_W-1:0] kind_out;
        logic                  final_result;
        logic                  empty_set;
        logic                  capacity_overflow;
    } t_out_beat;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
        logic shift;
        logic clear;
    } t_ses_cmd;

    // datapath to controller
    typedef struct packed {
        logic head_ok;
        logic next_ok;
    } t_ses_stat;

endpackage

>>> hw/rtl/section_extent_sorter_top.sv
// channel     | handshake                  | payload
// ------------+----------------------------+---------------------------------
// record in   | start, busy                | i_in_beat  (offset, kind, last)
// result out  | o_strobe                   | o_result   (start, end, kind, flags)
// limit write | i_cfg_we                   | i_cfg_wdata
//
// records load at one beat per cycle while busy is low, each going straight
// into a sorted row of cells with parallel compares against every cell
// after the marked record busy stays high until the last surviving section, or
// the empty marker, is out, while the row shifts down one cell per result
// each result appears in the cycle after its emit cycle and lasts one cycle
// synchronous active-low reset, no clearing pass; the receiver cannot stall
module section_extent_sorter_top
    import ses_pkg::*;
#(
    parameter int MAX_SECTIONS = SES_MAX_SECTIONS
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // record beats
    input  logic                 start,
    output logic                 busy,
    input  t_in_beat             i_in_beat,
    // block_limit register
    input  logic                 i_cfg_we,
    input  logic [SES_OFF_W-1:0] i_cfg_wdata,
    // result beats
    output logic                 o_strobe,
    output t_out_beat            o_result
);

    t_ses_cmd  w_cmd;
    t_ses_stat w_stat;

    // sequencing: load while idle, then walk the sorted row out
    ses_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_in_beat.last_record),
        .i_stat  (w_stat),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    // sorted cell row, record count, overflow flag, limit and result register
    ses_chain #(
        .MaxSections (MAX_SECTIONS)
    ) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_beat   (i_in_beat),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

>>> hw/rtl/ses_ctrl.sv
`include "section_extent_sorter_top_defines.svh"

module ses_ctrl
    import ses_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_last,
    input  t_ses_stat i_stat,
    output logic      o_busy,
    output t_ses_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_LOAD = 2'b01,
        S_EMIT = 2'b10
    } t_ses_state;

    t_ses_state r_state;
    t_ses_state n_state;
    logic       w_final;

    assign o_busy  = (r_state == S_EMIT);
    assign w_final = !(i_stat.head_ok && i_stat.next_ok);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (w_final) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_LOAD;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    `SES_CHK_NXT(a_last_starts_emit, i_clk, i_rst_n, (o_cmd.load && i_last), (r_state == S_EMIT), "marked beat did not start emission")
    `SES_CHK_NXT(a_final_ends_emit, i_clk, i_rst_n, (r_state == S_EMIT && w_final), (r_state == S_LOAD), "emission did not end after final result")

endmodule

>>> hw/rtl/ses_chain.sv
`include "section_extent_sorter_top_defines.svh"

module ses_chain
    import ses_pkg::*;
#(
    parameter int MaxSections = SES_MAX_SECTIONS
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [SES_OFF_W-1:0] i_cfg_wdata,
    input  t_in_beat             i_in_beat,
    input  t_ses_cmd             i_cmd,
    output t_ses_stat            o_stat,
    output logic                 o_strobe,
    output t_out_beat            o_result
);

    localparam int CntW = $clog2(MaxSections + 1);

    // sorted cell row, ascending offsets, valid cells packed from cell 0
    logic [SES_OFF_W-1:0]  r_off  [MaxSections];
    logic [SES_KIND_W-1:0] r_kind [MaxSections];
    logic [MaxSections-1:0] r_vld;
    logic [SES_OFF_W-1:0]  n_off  [MaxSections];
    logic [SES_KIND_W-1:0] n_kind [MaxSections];
    logic [MaxSections-1:0] n_vld;

    logic [CntW-1:0]      r_count;
    logic                 r_ovf;
    logic [SES_OFF_W-1:0] r_limit;
    logic                 r_strobe;
    t_out_beat            r_result;
    t_out_beat            n_result;

    logic [MaxSections-1:0] w_lt;
    logic [MaxSections-1:0] w_eq;
    logic [MaxSections-1:0] w_lt_prev;
    logic                   w_full;
    logic                   w_ins;
    logic                   w_hit;

    assign w_full    = (r_count == CntW'(MaxSections));
    assign w_ins     = i_cmd.load && !w_full && (i_in_beat.section_offset != '0);
    assign w_hit     = |w_eq;
    assign w_lt_prev = {w_lt[MaxSections-2:0], 1'b1};

    for (genvar g = 0; g < MaxSections; g++) begin : g_cell
        logic [SES_OFF_W-1:0]  w_dn_off;
        logic [SES_KIND_W-1:0] w_dn_kind;
        logic                  w_dn_vld;
        logic [SES_OFF_W-1:0]  w_up_off;
        logic [SES_KIND_W-1:0] w_up_kind;
        logic                  w_up_vld;

        assign w_lt[g] = r_vld[g] && (r_off[g] < i_in_beat.section_offset);
        assign w_eq[g] = r_vld[g] && (r_off[g] == i_in_beat.section_offset);

        if (g == 0) begin : g_bot
            assign w_dn_off  = i_in_beat.section_offset;
            assign w_dn_kind = i_in_beat.section_kind;
            assign w_dn_vld  = 1'b1;
        end else begin : g_mid
            assign w_dn_off  = r_off[g-1];
            assign w_dn_kind = r_kind[g-1];
            assign w_dn_vld  = r_vld[g-1];
        end

        if (g == MaxSections - 1) begin : g_top
            assign w_up_off  = '0;
            assign w_up_kind = '0;
            assign w_up_vld  = 1'b0;
        end else begin : g_low
            assign w_up_off  = r_off[g+1];
            assign w_up_kind = r_kind[g+1];
            assign w_up_vld  = r_vld[g+1];
        end

        always_comb begin
            n_off[g]  = r_off[g];
            n_kind[g] = r_kind[g];
            n_vld[g]  = r_vld[g];
            if (i_cmd.clear) begin
                n_vld[g] = 1'b0;
            end else if (i_cmd.shift) begin
                n_off[g]  = w_up_off;
                n_kind[g] = w_up_kind;
                n_vld[g]  = w_up_vld;
            end else if (w_ins) begin
                if (w_hit) begin
                    // equal offset: later record takes over the cell
                    if (w_eq[g]) begin
                        n_kind[g] = i_in_beat.section_kind;
                    end
                end else if (!w_lt[g]) begin
                    if (w_lt_prev[g]) begin
                        n_off[g]  = i_in_beat.section_offset;
                        n_kind[g] = i_in_beat.section_kind;
                        n_vld[g]  = 1'b1;
                    end else begin
                        n_off[g]  = w_dn_off;
                        n_kind[g] = w_dn_kind;
                        n_vld[g]  = w_dn_vld;
                    end
                end
            end
        end
    end

    assign o_stat.head_ok = r_vld[0] && (r_off[0] < r_limit);
    assign o_stat.next_ok = r_vld[1] && (r_off[1] < r_limit);

    always_comb begin
        n_result                   = '0;
        n_result.capacity_overflow = r_ovf;
        if (o_stat.head_ok) begin
            n_result.start_offset = r_off[0];
            n_result.end_offset   = o_stat.next_ok ? r_off[1] : r_limit;
            n_result.kind_out     = r_kind[0];
            n_result.final_result = !o_stat.next_ok;
        end else begin
            n_result.final_result = 1'b1;
            n_result.empty_set    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_limit  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= n_vld;
            r_strobe <= i_cmd.emit;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.load) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MaxSections; i++) begin
            r_off[i]  <= n_off[i];
            r_kind[i] <= n_kind[i];
        end
        if (i_cmd.emit) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `SES_CHK_NOW(a_vld_packed, i_clk, i_rst_n, 1'b1, ((r_vld & (r_vld + 1'b1)) == '0), "valid cells not packed from the bottom")
    `SES_CHK_NOW(a_cells_le_count, i_clk, i_rst_n, 1'b1, ($countones(r_vld) <= int'(r_count)), "more valid cells than stored records")
    `SES_CHK_NXT(a_clear_empties, i_clk, i_rst_n, i_cmd.clear, (r_vld == '0 && r_count == '0 && !r_ovf), "run state not cleared after final result")

endmodule

>>> tb/section_extent_sorter_top_tb.sv
module section_extent_sorter_top_tb;
    import ses_pkg::*;

    localparam int          MAX_REC      = SES_MAX_SECTIONS;
    localparam int          DIR_ROWS     = 25;
    localparam int          RAND_ITEMS   = 185;
    // no idling once this many random records have gone in
    localparam int          CALM_TAIL_AT = 155;
    // cycles to let pass once the last expected extent is out
    localparam int          SETTLE_CYCLES = 4;
    // longest stretch with no beat on any port: the longest idle gap, a settle
    // pause and up to 32 results of emission stay far below this
    localparam int          QUIET_LIMIT  = 2000;
    localparam int          PRINT_CAP    = 50;

    typedef enum logic {ROW_LIMIT, ROW_RECORD} t_row_op;

    // one line of the directed plan: either a limit write or a record beat,
    // optionally with its single result typed in
    typedef struct {
        t_row_op               op;
        logic [SES_OFF_W-1:0]  value;
        logic [SES_KIND_W-1:0] kind;
        logic                  last;
        bit                    pinned;
        t_out_beat             exp;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_in_beat             i_in_beat = '0;
    logic                 i_cfg_we = 1'b0;
    logic [SES_OFF_W-1:0] i_cfg_wdata = '0;
    logic                 o_strobe;
    t_out_beat            o_result;

    // typed expectation travels alongside the record beat it belongs to
    bit                   pin_valid = 1'b0;
    t_out_beat            pin_beat = '0;

    // shadow of the block: limit register and the records of the open set
    logic [SES_OFF_W-1:0]  limit_shadow = '0;
    logic [SES_OFF_W-1:0]  held_off [MAX_REC];
    logic [SES_KIND_W-1:0] held_kind [MAX_REC];
    int unsigned           held_count = 0;
    bit                    held_over = 1'b0;

    t_out_beat             fresh_q [$];   // extents of the set just closed
    t_out_beat             extent_q [$];  // extents still to come out of the block
    logic [SES_OFF_W-1:0]  set_offsets [$];

    int unsigned mismatches = 0;
    int unsigned n_records = 0;
    int unsigned n_sets = 0;
    int unsigned n_empty = 0;
    int unsigned n_overflow_sets = 0;
    int unsigned n_results = 0;
    int unsigned n_limits = 0;
    int unsigned quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    section_extent_sorter_top #(
        .MAX_SECTIONS (SES_MAX_SECTIONS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in_beat   (i_in_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < PRINT_CAP) begin
            $display("mismatch %s: got %h want %h (cycle time %0t)", what, got, want, $time);
        end
        mismatches++;
    endtask

    // stores one record and, when it closes the set, works out the extents:
    // in-range offsets only, latest record wins on equal offsets, ascending order
    task automatic absorb_record(input t_in_beat b);
        logic [SES_OFF_W-1:0]  srt_off [MAX_REC];
        logic [SES_KIND_W-1:0] srt_kind [MAX_REC];
        int unsigned           m;
        int unsigned           k;
        bit                    keep;
        t_out_beat             r;
        fresh_q.delete();
        if (held_count < MAX_REC) begin
            held_off[held_count]  = b.section_offset;
            held_kind[held_count] = b.section_kind;
            held_count++;
        end else begin
            // no room: the record is lost, even a marked one
            held_over = 1'b1;
        end
        if (!b.last_record) return;

        m = 0;
        for (int i = 0; i < held_count; i++) begin
            keep = held_off[i] != '0 && held_off[i] < limit_shadow;
            for (int j = i + 1; keep && j < held_count; j++) begin
                if (held_off[j] == held_off[i]) keep = 1'b0;
            end
            if (keep) begin
                k = m;
                while (k > 0 && srt_off[k-1] > held_off[i]) begin
                    srt_off[k]  = srt_off[k-1];
                    srt_kind[k] = srt_kind[k-1];
                    k--;
                end
                srt_off[k]  = held_off[i];
                srt_kind[k] = held_kind[i];
                m++;
            end
        end

        n_sets++;
        if (held_over) n_overflow_sets++;
        if (m == 0) begin
            // nothing survived: one empty marker beat
            r = '0;
            r.final_result      = 1'b1;
            r.empty_set         = 1'b1;
            r.capacity_overflow = held_over;
            fresh_q.push_back(r);
            n_empty++;
        end else begin
            for (int i = 0; i < m; i++) begin
                r.start_offset      = srt_off[i];
                r.end_offset        = (i + 1 < m) ? srt_off[i+1] : limit_shadow;
                r.kind_out          = srt_kind[i];
                r.final_result      = (i + 1 == m);
                r.empty_set         = 1'b0;
                r.capacity_overflow = held_over;
                fresh_q.push_back(r);
            end
        end
        // the next beat opens a new set; the limit stays
        held_count = 0;
        held_over  = 1'b0;
    endtask

    task automatic check_extent(input t_out_beat got);
        t_out_beat want;
        if (extent_q.size() == 0) begin
            flag_mismatch("result beat with nothing expected", got.start_offset, '0);
            return;
        end
        want = extent_q.pop_front();
        if (got.start_offset !== want.start_offset)
            flag_mismatch("start_offset", got.start_offset, want.start_offset);
        if (got.end_offset !== want.end_offset)
            flag_mismatch("end_offset", got.end_offset, want.end_offset);
        if (got.kind_out !== want.kind_out)
            flag_mismatch("kind_out", 32'(got.kind_out), 32'(want.kind_out));
        if (got.final_result !== want.final_result)
            flag_mismatch("final_result", 32'(got.final_result), 32'(want.final_result));
        if (got.empty_set !== want.empty_set)
            flag_mismatch("empty_set", 32'(got.empty_set), 32'(want.empty_set));
        if (got.capacity_overflow !== want.capacity_overflow)
            flag_mismatch("capacity_overflow", 32'(got.capacity_overflow),
                          32'(want.capacity_overflow));
    endtask

    // monitor: everything sampled at the rising edge, before the block's own
    // updates of that edge land; limit write first, then the record beat,
    // then the result beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) limit_shadow = i_cfg_wdata;
            if (start && !busy) begin
                n_records++;
                absorb_record(i_in_beat);
                if (i_in_beat.last_record) begin
                    // a typed row stands in for the computed extents
                    if (pin_valid) extent_q.push_back(pin_beat);
                    else foreach (fresh_q[i]) extent_q.push_back(fresh_q[i]);
                end
            end
            if (o_strobe) begin
                n_results++;
                check_extent(o_result);
            end
        end
    end

    // watchdog: ends the run if no beat moves on any port for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe || i_cfg_we) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no beat for %0d cycles, %0d extents pending",
                         quiet_cycles, extent_q.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // presents one record beat after an optional idle burst and returns at
    // the edge that takes it; start is left high for a back-to-back beat
    task automatic push_record(input t_in_beat b, input bit pin, input t_out_beat pexp,
                               input int unsigned gap);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_in_beat <= b;
        pin_valid <= pin;
        pin_beat  <= pexp;
        do @(posedge i_clk); while (busy);
    endtask

    // stop sending and wait for every expected extent, then a short pause so
    // the block is idle before a limit write or the end of the run
    task automatic settle_block();
        start <= 1'b0;
        @(posedge i_clk);
        while (extent_q.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [SES_OFF_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        n_limits++;
    endtask

    function automatic int unsigned idle_gap(input bit calm);
        if (calm || $urandom_range(3, 0) != 0) return 0;
        return $urandom_range(7, 1);
    endfunction

    // offsets aimed at the edges: zero, at or past the limit, repeats within
    // the set, and plain values below the limit
    function automatic logic [SES_OFF_W-1:0] pick_offset(input logic [SES_OFF_W-1:0] lim);
        case ($urandom_range(15, 0))
            0: return '0;
            1: return (lim != 0) ? lim : 32'hFFFF_FFFF;
            2: return $urandom;
            3: return (set_offsets.size() != 0) ?
                      set_offsets[$urandom_range(set_offsets.size() - 1, 0)] : 32'd1;
            4: return (lim > 1) ? lim - 1 : 32'd1;
            5: return 32'd1;
            default: return (lim > 1) ? $urandom_range(lim - 1, 1) : $urandom;
        endcase
    endfunction

    function automatic t_row rec(input logic [31:0] off, input logic [6:0] kind,
                                 input logic last);
        t_row r;
        r.op     = ROW_RECORD;
        r.value  = off;
        r.kind   = kind;
        r.last   = last;
        r.pinned = 1'b0;
        r.exp    = '0;
        return r;
    endfunction

    function automatic t_row lim(input logic [31:0] v);
        t_row r;
        r       = rec(v, '0, 1'b0);
        r.op    = ROW_LIMIT;
        return r;
    endfunction

    // marked record whose only extent is typed in
    function automatic t_row pin(input logic [31:0] off, input logic [6:0] kind,
                                 input logic [31:0] s, input logic [31:0] e,
                                 input logic [6:0] k);
        t_row r;
        r        = rec(off, kind, 1'b1);
        r.pinned = 1'b1;
        r.exp    = '{s, e, k, 1'b1, 1'b0, 1'b0};
        return r;
    endfunction

    // marked record that leaves nothing: the empty marker beat
    function automatic t_row pin_empty(input logic [31:0] off, input logic [6:0] kind);
        t_row r;
        r     = pin(off, kind, '0, '0, '0);
        r.exp = '{32'd0, 32'd0, 7'd0, 1'b1, 1'b1, 1'b0};
        return r;
    endfunction

    initial begin
        t_row        plan [DIR_ROWS];
        t_in_beat    beat;
        int unsigned rand_items;
        int unsigned set_idx;
        int unsigned set_len;
        bit          calm;

        plan = '{
            // limit still zero after reset: everything dropped
            pin_empty(32'd5, 7'h03),
            lim(32'hFFFF_FFFF),
            // highest offset below the limit with top kind, ends at the limit
            pin(32'hFFFF_FFFE, 7'h7F, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 7'h7F),
            // offset equal to the limit, then the absent offset
            pin_empty(32'hFFFF_FFFF, 7'h00),
            pin_empty(32'd0, 7'h01),
            // mixed set: out of order, a repeat where the later kind wins, a zero
            rec(32'd100, 7'h01, 1'b0),
            rec(32'd50, 7'h02, 1'b0),
            rec(32'd100, 7'h03, 1'b0),
            rec(32'd0, 7'h04, 1'b0),
            rec(32'd1, 7'h05, 1'b1),
            pin(32'd1, 7'h55, 32'd1, 32'hFFFF_FFFF, 7'h55),
            lim(32'd1000),
            rec(32'd999, 7'h2A, 1'b0),
            rec(32'd1000, 7'h01, 1'b0),
            rec(32'd500, 7'h15, 1'b1),
            // three equal offsets: only the last one stays
            rec(32'd7, 7'h01, 1'b0),
            rec(32'd7, 7'h02, 1'b0),
            pin(32'd7, 7'h03, 32'd7, 32'd1000, 7'h03),
            lim(32'd1),
            pin_empty(32'd1, 7'h6A),
            lim(32'h8000_0000),
            rec(32'h7FFF_FFFF, 7'h11, 1'b0),
            rec(32'h8000_0000, 7'h22, 1'b1),
            lim(32'd0),
            pin_empty(32'h0000_1234, 7'h40)
        };

        // reset held low from the start, released once
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed plan
        foreach (plan[r]) begin
            if (plan[r].op == ROW_LIMIT) begin
                settle_block();
                set_limit(plan[r].value);
            end else begin
                beat = '{plan[r].value, plan[r].kind, plan[r].last};
                push_record(beat, plan[r].pinned, plan[r].exp, idle_gap(1'b0));
            end
        end

        // random sets: mostly short, a few that fill or overrun the store
        rand_items = 0;
        set_idx    = 0;
        while (rand_items < RAND_ITEMS) begin
            if (set_idx % 6 == 0 && rand_items < CALM_TAIL_AT) begin
                settle_block();
                case ($urandom_range(6, 0))
                    0: set_limit('0);
                    1: set_limit(32'd1);
                    2: set_limit(32'hFFFF_FFFF);
                    3: set_limit(32'd64);
                    4: set_limit(32'h0001_0000);
                    5: set_limit($urandom_range(200, 2));
                    default: set_limit($urandom);
                endcase
            end
            if (set_idx == 2) set_len = MAX_REC + 1;         // marked beat lost to overflow
            else if (set_idx == 5) set_len = MAX_REC;        // exactly full
            else if (set_idx == 9) set_len = MAX_REC + 8;
            else if ($urandom_range(14, 0) == 0) set_len = $urandom_range(MAX_REC + 8, MAX_REC + 1);
            else set_len = $urandom_range(10, 1);
            calm = ($urandom_range(2, 0) == 0);
            set_offsets.delete();
            for (int k = 0; k < set_len; k++) begin
                beat.section_offset = pick_offset(limit_shadow);
                beat.section_kind   = $urandom_range(127, 0);
                beat.last_record    = (k == set_len - 1);
                set_offsets.push_back(beat.section_offset);
                push_record(beat, 1'b0, '0, idle_gap(calm || rand_items >= CALM_TAIL_AT));
                rand_items++;
            end
            // now and then hold off until the whole set has come out
            if (rand_items < CALM_TAIL_AT && $urandom_range(4, 0) == 0) settle_block();
            set_idx++;
        end

        settle_block();
        repeat (8) @(posedge i_clk);
        if (extent_q.size() != 0) flag_mismatch("extents never produced", extent_q.size(), '0);

        $display("ran %0d records in %0d sets under %0d limit settings, %0d extents checked",
                 n_records, n_sets, n_limits, n_results);
        $display("%0d sets came out empty, %0d overran the %0d-record store",
                 n_empty, n_overflow_sets, MAX_REC);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
